FILE: rtl/core/ccnsa_pkg.sv
// shared constants and codes for the cover-crop scaler address block
`timescale 1ns / 1ps
package ccnsa_pkg;

  localparam int DIM_W       = 13;   // configuration register width
  localparam int COORD_W     = 12;   // coordinate field width
  localparam int OFF_W       = 26;   // raster byte offset width
  localparam int CFG_IDX_W   = 3;
  localparam int MAX_DIM_DEF = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_DST_W = 3'd2,
    REG_DST_H = 3'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_PROD,
    ST_SELECT,
    ST_DIV,
    ST_FINISH,
    ST_RUN
  } setup_state_t;

endpackage

FILE: rtl/core/ccnsa_if.sv
// coordinate and address channel interfaces
`timescale 1ns / 1ps
interface ccnsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [ccnsa_pkg::COORD_W-1:0] dest_col;
  logic [ccnsa_pkg::COORD_W-1:0] dest_row;
  modport source (output valid, dest_col, dest_row, input ready);
  modport sink   (input valid, dest_col, dest_row, output ready);
endinterface

interface ccnsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ccnsa_pkg::COORD_W-1:0] src_col;
  logic [ccnsa_pkg::COORD_W-1:0] src_row;
  logic [ccnsa_pkg::OFF_W-1:0]   raster_offset;
  logic                          coord_ok;
  modport source (output valid, src_col, src_row, raster_offset, coord_ok, input ready);
  modport sink   (input valid, src_col, src_row, raster_offset, coord_ok, output ready);
endinterface

FILE: rtl/core/cover_crop_nearest_scaler_address.sv
// cover-crop nearest-neighbor scaler address generator, top level
//
//  channel   dir  payload                                        handshake
//  pix_in    in   dest_col, dest_row                             valid/ready
//  pix_out   out  src_col, src_row, raster_offset, coord_ok      valid/ready
//  cfg       in   cfg_index, cfg_data                            cfg_we only
//
//  one coordinate per clock while pix_in.ready is high, through the front and
//  prep stages, the division cells (one quotient bit per cell) and tail stages
//  after reset and after every config write, pix_in.ready stays low while the
//  iterative crop divider runs
//  output stalls back up stage by stage; empty stages keep filling
//  reset is synchronous, active high, clears the valid bits and the setup
//  sequencer, and sets the dimension registers to one
`timescale 1ns / 1ps
module cover_crop_nearest_scaler_address #(
  parameter int MAX_DIM = ccnsa_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ccnsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccnsa_pkg::DIM_W-1:0]     cfg_data,
  ccnsa_in_if.sink                        pix_in,
  ccnsa_out_if.source                     pix_out
);
  import ccnsa_pkg::*;

  // internal dimension width follows the saturation limit
  localparam int DW  = ($clog2(MAX_DIM + 1) > DIM_W) ? DIM_W : $clog2(MAX_DIM + 1);
  localparam int NW  = COORD_W + 1 + DW;   // (2d+1) * crop length
  localparam int NST = DW + 5;             // front, prep, cells, three tail stages
  localparam int T0  = DW + 2;
  localparam int T1  = DW + 3;
  localparam int T2  = DW + 4;

  logic [DW-1:0] sw, sh, tw, th, crop_x, crop_w, crop_y, crop_h;
  logic          busy;

  ccnsa_setup #(.MAX_DIM(MAX_DIM), .DW(DW)) u_setup (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .sw, .sh, .tw, .th, .crop_x, .crop_w, .crop_y, .crop_h, .busy
  );

  // stage valids and per-stage load enables; a stage loads when empty or moving on
  logic [NST-1:0] v, adv;
  logic           take;

  always_comb begin
    adv[NST-1] = !v[NST-1] || pix_out.ready;
    for (int i = NST - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign take         = pix_in.valid && !busy;
  assign pix_in.ready = adv[0] && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= take;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // divisors: twice the destination length
  logic [DW:0] den_x, den_y;
  assign den_x = {tw, 1'b0};
  assign den_y = {th, 1'b0};

  // front: centre-sample numerators and the inside flag
  logic [NW-1:0] num_x, num_y;
  logic          ok0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num_x <= NW'({pix_in.dest_col, 1'b1}) * NW'(crop_w);
      num_y <= NW'({pix_in.dest_row, 1'b1}) * NW'(crop_h);
      ok0   <= (32'(pix_in.dest_col) < 32'(tw)) && (32'(pix_in.dest_row) < 32'(th));
    end
  end

  // cell row data; entry 0 is the prep stage, entry k+1 leaves cell k
  logic          ok_c  [DW+1];
  logic          ovx_c [DW+1];
  logic          ovy_c [DW+1];
  logic [DW:0]   remx_c[DW+1];
  logic [DW:0]   remy_c[DW+1];
  logic [DW-1:0] lox_c [DW+1];
  logic [DW-1:0] loy_c [DW+1];

  // prep registers
  logic          ok_p, ovx_p, ovy_p;
  logic [DW:0]   remx_p, remy_p;
  logic [DW-1:0] lox_p, loy_p;

  // prep: a quotient of 2^DW or more always clamps, so flag it and skip
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ok_p   <= ok0;
      ovx_p  <= (32'(num_x[NW-1:DW]) >= 32'(den_x));
      ovy_p  <= (32'(num_y[NW-1:DW]) >= 32'(den_y));
      remx_p <= (DW+1)'(num_x[NW-1:DW]);
      remy_p <= (DW+1)'(num_y[NW-1:DW]);
      lox_p  <= num_x[DW-1:0];
      loy_p  <= num_y[DW-1:0];
    end
  end

  assign ok_c[0]   = ok_p;
  assign ovx_c[0]  = ovx_p;
  assign ovy_c[0]  = ovy_p;
  assign remx_c[0] = remx_p;
  assign remy_c[0] = remy_p;
  assign lox_c[0]  = lox_p;
  assign loy_c[0]  = loy_p;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    ccnsa_cell #(.DW(DW)) u_cell (
      .clk,
      .ld      (adv[k+2]),
      .den_x, .den_y,
      .ok_in   (ok_c[k]),
      .ovx_in  (ovx_c[k]),
      .remx_in (remx_c[k]),
      .lox_in  (lox_c[k]),
      .ovy_in  (ovy_c[k]),
      .remy_in (remy_c[k]),
      .loy_in  (loy_c[k]),
      .ok_out  (ok_c[k+1]),
      .ovx_out (ovx_c[k+1]),
      .remx_out(remx_c[k+1]),
      .lox_out (lox_c[k+1]),
      .ovy_out (ovy_c[k+1]),
      .remy_out(remy_c[k+1]),
      .loy_out (loy_c[k+1])
    );
  end

  // tail 0: add crop start, clamp to last column / row
  logic [DW:0]   sum_x, sum_y;
  logic [DW-1:0] sx0, sy0;
  logic          ok1;

  assign sum_x = (DW+1)'(crop_x) + (DW+1)'(lox_c[DW]);
  assign sum_y = (DW+1)'(crop_y) + (DW+1)'(loy_c[DW]);

  always_ff @(posedge clk) begin
    if (adv[T0]) begin
      sx0 <= (ovx_c[DW] || sum_x >= (DW+1)'(sw)) ? DW'(sw - DW'(1)) : DW'(sum_x);
      sy0 <= (ovy_c[DW] || sum_y >= (DW+1)'(sh)) ? DW'(sh - DW'(1)) : DW'(sum_y);
      ok1 <= ok_c[DW];
    end
  end

  // tail 1: row times source width
  logic [2*DW-1:0] rowp;
  logic [DW-1:0]   sx1, sy1;
  logic            ok2;

  always_ff @(posedge clk) begin
    if (adv[T1]) begin
      rowp <= (2*DW)'(sy0) * (2*DW)'(sw);
      sx1  <= sx0;
      sy1  <= sy0;
      ok2  <= ok1;
    end
  end

  // tail 2: pixel index times three, output register
  logic [2*DW+1:0] pix_idx;
  assign pix_idx = (2*DW+2)'(rowp) + (2*DW+2)'(sx1);

  always_ff @(posedge clk) begin
    if (adv[T2]) begin
      pix_out.src_col       <= COORD_W'(sx1);
      pix_out.src_row       <= COORD_W'(sy1);
      pix_out.raster_offset <= OFF_W'((pix_idx << 1) + pix_idx);
      pix_out.coord_ok      <= ok2;
    end
  end

  assign pix_out.valid = v[T2];

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |=> !v[0])
    else $error("coordinate entered during geometry setup");
  a_clamp_col: assert property (@(posedge clk) disable iff (rst)
    v[T1] |-> (sx1 < sw) && (sy1 < sh))
    else $error("source pixel outside source image");
  a_prep_rem: assert property (@(posedge clk) disable iff (rst)
    v[1] && !ovx_c[0] |-> remx_c[0] < den_x)
    else $error("division remainder start out of range");

endmodule

FILE: rtl/core/ccnsa_setup.sv
// configuration registers and iterative crop geometry computation
`timescale 1ns / 1ps
module ccnsa_setup #(
  parameter int MAX_DIM = ccnsa_pkg::MAX_DIM_DEF,
  parameter int DW      = ccnsa_pkg::DIM_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ccnsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ccnsa_pkg::DIM_W-1:0]     cfg_data,
  output logic [DW-1:0]                   sw,
  output logic [DW-1:0]                   sh,
  output logic [DW-1:0]                   tw,
  output logic [DW-1:0]                   th,
  output logic [DW-1:0]                   crop_x,
  output logic [DW-1:0]                   crop_w,
  output logic [DW-1:0]                   crop_y,
  output logic [DW-1:0]                   crop_h,
  output logic                            busy
);
  import ccnsa_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DIM_W-1:0] raw_sw, raw_sh, raw_tw, raw_th;
  setup_state_t     state, state_next;
  logic             ld_prod, ld_sel, step, fin;
  logic [2*DW-1:0]  lhs, rhs;
  logic             mode_x, mode_y;
  logic [DW-1:0]    rem, lo, dvs;
  logic [CW-1:0]    cnt;
  logic [DW:0]      trial;
  logic             ge;
  logic [DW-1:0]    crop;

  function automatic logic [DW-1:0] eff(input logic [DIM_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (32'(v) > MAX_DIM) r = DW'(MAX_DIM);
    else r = DW'(v);
    return r;
  endfunction

  assign sw = eff(raw_sw);
  assign sh = eff(raw_sh);
  assign tw = eff(raw_tw);
  assign th = eff(raw_th);

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_sw <= DIM_W'(1);
      raw_sh <= DIM_W'(1);
      raw_tw <= DIM_W'(1);
      raw_th <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_W: raw_sw <= cfg_data;
        REG_SRC_H: raw_sh <= cfg_data;
        REG_DST_W: raw_tw <= cfg_data;
        REG_DST_H: raw_th <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_PROD;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = ST_PROD;
    end else begin
      unique case (state)
        ST_PROD:   state_next = ST_SELECT;
        ST_SELECT: state_next = ST_DIV;
        ST_DIV:    if (cnt == CW'(DW - 1)) state_next = ST_FINISH;
        ST_FINISH: state_next = ST_RUN;
        ST_RUN:    state_next = ST_RUN;
        default:   state_next = ST_PROD;
      endcase
    end
  end

  always_comb begin
    ld_prod = (state == ST_PROD);
    ld_sel  = (state == ST_SELECT);
    step    = (state == ST_DIV);
    fin     = (state == ST_FINISH);
    busy    = (state != ST_RUN);
  end

  // one quotient bit per cycle, quotient known to fit DW bits
  assign trial = {rem, lo[DW-1]};
  assign ge    = (trial >= {1'b0, dvs});
  assign crop  = (lo == '0) ? DW'(1) : lo;

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      lhs <= (2*DW)'(sw) * (2*DW)'(th);
      rhs <= (2*DW)'(sh) * (2*DW)'(tw);
    end
    if (ld_sel) begin
      mode_x <= (lhs > rhs);
      mode_y <= (lhs < rhs);
      cnt    <= '0;
      if (lhs > rhs) begin
        rem <= rhs[2*DW-1:DW];
        lo  <= rhs[DW-1:0];
        dvs <= th;
      end else begin
        rem <= lhs[2*DW-1:DW];
        lo  <= lhs[DW-1:0];
        dvs <= tw;
      end
    end
    if (step) begin
      rem <= ge ? DW'(trial - {1'b0, dvs}) : DW'(trial);
      lo  <= {lo[DW-2:0], ge};
      cnt <= cnt + CW'(1);
    end
    if (fin) begin
      if (mode_x) begin
        crop_w <= crop;
        crop_x <= DW'((sw - crop) >> 1);
        crop_h <= sh;
        crop_y <= '0;
      end else if (mode_y) begin
        crop_w <= sw;
        crop_x <= '0;
        crop_h <= crop;
        crop_y <= DW'((sh - crop) >> 1);
      end else begin
        crop_w <= sw;
        crop_x <= '0;
        crop_h <= sh;
        crop_y <= '0;
      end
    end
  end

  a_write_restarts: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("config write did not restart geometry setup");
  a_crop_w_sane: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (crop_w != '0) && (crop_w <= sw) && (32'(crop_x) + 32'(crop_w) <= 32'(sw)))
    else $error("horizontal crop outside source");
  a_crop_h_sane: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (crop_h != '0) && (crop_h <= sh) && (32'(crop_y) + 32'(crop_h) <= 32'(sh)))
    else $error("vertical crop outside source");

endmodule

FILE: rtl/core/ccnsa_cell.sv
// one restoring-division cell: one quotient bit for each axis
`timescale 1ns / 1ps
module ccnsa_cell #(
  parameter int DW = ccnsa_pkg::DIM_W
) (
  input  logic          clk,
  input  logic          ld,
  input  logic [DW:0]   den_x,
  input  logic [DW:0]   den_y,
  input  logic          ok_in,
  input  logic          ovx_in,
  input  logic [DW:0]   remx_in,
  input  logic [DW-1:0] lox_in,
  input  logic          ovy_in,
  input  logic [DW:0]   remy_in,
  input  logic [DW-1:0] loy_in,
  output logic          ok_out,
  output logic          ovx_out,
  output logic [DW:0]   remx_out,
  output logic [DW-1:0] lox_out,
  output logic          ovy_out,
  output logic [DW:0]   remy_out,
  output logic [DW-1:0] loy_out
);
  logic [DW+1:0] tx, ty;
  logic          gx, gy;

  assign tx = {remx_in, lox_in[DW-1]};
  assign ty = {remy_in, loy_in[DW-1]};
  assign gx = (tx >= {1'b0, den_x});
  assign gy = (ty >= {1'b0, den_y});

  always_ff @(posedge clk) begin
    if (ld) begin
      ok_out   <= ok_in;
      ovx_out  <= ovx_in;
      ovy_out  <= ovy_in;
      remx_out <= gx ? (DW+1)'(tx - {1'b0, den_x}) : (DW+1)'(tx);
      remy_out <= gy ? (DW+1)'(ty - {1'b0, den_y}) : (DW+1)'(ty);
      lox_out  <= {lox_in[DW-2:0], gx};
      loy_out  <= {loy_in[DW-2:0], gy};
    end
  end

endmodule
